FILE: src/ccmk_pkg.sv
// Shared constants and types of the circular canonical minimum k-mer hash.
package ccmk_pkg;

    // k-mer length in bases and the derived widths
    localparam int KMER_LEN   = 16;
    localparam int KMER_W     = 2 * KMER_LEN;
    localparam int RUN_W      = $clog2(KMER_LEN + 1);
    localparam int MIN_W      = 32;

    // head store: first KMER_LEN-1 bases, replayed at the end of a sequence
    localparam int REPLAY_LEN = KMER_LEN - 1;
    localparam int HEAD_DEPTH = (REPLAY_LEN > 0) ? REPLAY_LEN : 1;
    localparam int HEAD_IDX_W = (HEAD_DEPTH > 1) ? $clog2(HEAD_DEPTH) : 1;
    localparam int HEAD_CNT_W = (REPLAY_LEN > 0) ? $clog2(REPLAY_LEN + 1) : 1;

    // minimum when no k-mer was seen
    localparam logic [MIN_W-1:0] MIN_NONE = {MIN_W{1'b1}};

    // classified base: bad marks a character that is not a nucleotide
    typedef struct packed {
        logic       bad;
        logic [1:0] base;
    } code_t;

    // one queued beat from the front to the back
    typedef struct packed {
        code_t code;
        logic  last;
    } item_t;

endpackage

FILE: src/ccmk_in_if.sv
// Input channel: one character of the sequence per beat.
interface ccmk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_char;
    logic       last_base;

    modport source (output valid, output base_char, output last_base, input ready);
    modport sink   (input valid, input base_char, input last_base, output ready);
endinterface

FILE: src/ccmk_out_if.sv
// Output channel: one minimum code per sequence.
interface ccmk_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] min_code;

    modport source (output valid, output min_code, input ready);
    modport sink   (input valid, input min_code, output ready);
endinterface

FILE: src/ccmk_front.sv
// Front part: accepts characters, classifies them and queues them for the back part.
module ccmk_front (
    input  logic            clk,
    input  logic            rst_n,
    ccmk_in_if.sink         in_chan,
    output logic            q_valid,
    input  logic            q_ready,
    output ccmk_pkg::item_t q_item
);

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // character to two-bit base, or bad
    function automatic ccmk_pkg::code_t map_char(input logic [7:0] ch);
        ccmk_pkg::code_t c;
        c.bad  = 1'b0;
        c.base = 2'd0;
        case (ch)
            8'h41, 8'h61:               c.base = 2'd0;
            8'h43, 8'h63:               c.base = 2'd1;
            8'h47, 8'h67:               c.base = 2'd2;
            8'h54, 8'h74, 8'h55, 8'h75: c.base = 2'd3;
            default:                    c.bad  = 1'b1;
        endcase
        return c;
    endfunction

    ccmk_pkg::item_t   queue_mem [QUEUE_DEPTH];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;
    ccmk_pkg::item_t   new_item;

    assign in_chan.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push          = in_chan.valid && in_chan.ready;
    assign q_valid       = (count_reg != '0);
    assign pop           = q_valid && q_ready;
    assign q_item        = queue_mem[rd_ptr_reg];

    always_comb
    begin
        new_item.code = map_char(in_chan.base_char);
        new_item.last = in_chan.last_base;
    end

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

FILE: src/ccmk_back.sv
// Back part: rolling k-mer, canonical minimum, head replay and result register.
module ccmk_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  ccmk_pkg::item_t q_item,
    ccmk_out_if.source      out_chan
);

    localparam logic [1:0] S_RUN    = 2'd0;
    localparam logic [1:0] S_REPLAY = 2'd1;
    localparam logic [1:0] S_DONE   = 2'd2;

    localparam int KW  = ccmk_pkg::KMER_W;
    localparam int CW  = ccmk_pkg::HEAD_CNT_W;
    localparam int IW  = ccmk_pkg::HEAD_IDX_W;
    localparam int MW  = ccmk_pkg::MIN_W;
    localparam int RW  = ccmk_pkg::RUN_W;

    // digits reversed, each replaced by 3-d
    function automatic logic [KW-1:0] rev_comp(input logic [KW-1:0] code);
        logic [KW-1:0] r;
        r = '0;
        for (int i = 0; i < ccmk_pkg::KMER_LEN; i++)
        begin
            r[2*(ccmk_pkg::KMER_LEN-1-i) +: 2] = ~code[2*i +: 2];
        end
        return r;
    endfunction

    logic [1:0]      state_reg, state_next;
    logic [KW-1:0]   kmer_reg, kmer_next;
    logic [RW-1:0]   run_reg, run_next;
    logic [MW-1:0]   min_reg, min_next;
    logic [CW-1:0]   head_count_reg, head_count_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   step_reg, step_next;
    logic            out_valid_reg, out_valid_next;
    logic [MW-1:0]   out_data_reg, out_data_next;

    ccmk_pkg::code_t head_mem [ccmk_pkg::HEAD_DEPTH];
    logic            head_wr;

    ccmk_pkg::code_t feed_code;
    logic            feed_en;
    logic [KW-1:0]   kmer_shift;
    logic [RW-1:0]   run_inc;
    logic [MW-1:0]   fwd_code, rc_code, best_min;
    logic            c_lt, r_lt, c_lt_r;
    logic            out_free;
    logic [CW-1:0]   ptr_inc;

    assign q_ready           = (state_reg == S_RUN);
    assign out_chan.valid    = out_valid_reg;
    assign out_chan.min_code = out_data_reg;
    assign out_free          = !out_valid_reg || out_chan.ready;

    // base for this cycle: queued beat or replayed head entry
    always_comb
    begin
        if (state_reg == S_RUN)
        begin
            feed_code = q_item.code;
        end
        else
        begin
            feed_code = head_mem[ptr_reg[IW-1:0]];
        end
        feed_en = (state_reg == S_RUN && q_valid) || (state_reg == S_REPLAY);
    end

    // rolling k-mer and canonical candidate
    always_comb
    begin
        kmer_shift = KW'({feed_code.base, kmer_reg} >> 2);
        run_inc    = (run_reg < RW'(ccmk_pkg::KMER_LEN)) ? run_reg + RW'(1) : run_reg;
        fwd_code   = MW'(kmer_shift);
        rc_code    = MW'(rev_comp(kmer_shift));
        c_lt       = fwd_code < min_reg;
        r_lt       = rc_code < min_reg;
        c_lt_r     = fwd_code < rc_code;
        if (c_lt && (c_lt_r || !r_lt))
        begin
            best_min = fwd_code;
        end
        else if (r_lt)
        begin
            best_min = rc_code;
        end
        else
        begin
            best_min = min_reg;
        end
    end

    assign ptr_inc = ptr_reg + CW'(1);

    // sequencer: run, replay head, deliver result
    always_comb
    begin
        state_next      = state_reg;
        kmer_next       = kmer_reg;
        run_next        = run_reg;
        min_next        = min_reg;
        head_count_next = head_count_reg;
        ptr_next        = ptr_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !out_chan.ready;
        out_data_next   = out_data_reg;
        head_wr         = 1'b0;

        if (feed_en)
        begin
            if (feed_code.bad)
            begin
                kmer_next = '0;
                run_next  = '0;
            end
            else
            begin
                kmer_next = kmer_shift;
                run_next  = run_inc;
                if (run_inc == RW'(ccmk_pkg::KMER_LEN))
                begin
                    min_next = best_min;
                end
            end
        end

        case (state_reg)
            S_RUN:
            begin
                if (q_valid)
                begin
                    if (head_count_reg < CW'(ccmk_pkg::REPLAY_LEN))
                    begin
                        head_wr         = 1'b1;
                        head_count_next = head_count_reg + CW'(1);
                    end
                    if (q_item.last)
                    begin
                        ptr_next  = '0;
                        step_next = '0;
                        if (ccmk_pkg::REPLAY_LEN > 0)
                        begin
                            state_next = S_REPLAY;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_REPLAY:
            begin
                ptr_next  = (ptr_inc == head_count_reg) ? '0 : ptr_inc;
                step_next = step_reg + CW'(1);
                if (step_reg == CW'(ccmk_pkg::REPLAY_LEN - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = min_reg;
                    kmer_next       = '0;
                    run_next        = '0;
                    min_next        = ccmk_pkg::MIN_NONE;
                    head_count_next = '0;
                    state_next      = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_RUN;
            kmer_reg       <= '0;
            run_reg        <= '0;
            min_reg        <= ccmk_pkg::MIN_NONE;
            head_count_reg <= '0;
            ptr_reg        <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kmer_reg       <= kmer_next;
            run_reg        <= run_next;
            min_reg        <= min_next;
            head_count_reg <= head_count_next;
            ptr_reg        <= ptr_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload and head store
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (head_wr)
        begin
            head_mem[head_count_reg[IW-1:0]] <= q_item.code;
        end
    end

endmodule

FILE: src/circular_canonical_min_kmer_hash.sv
// Top level of the circular canonical minimum k-mer hash.
//
// in_chan carries one ASCII character per beat; last_base marks the final
// character of a circular sequence. out_chan carries one beat per sequence:
// min_code, the smallest canonical k-mer code (forward or reverse
// complement), all ones when the sequence held no complete k-mer.
// Characters are taken at one beat per cycle while the queue has room. A
// two-entry queue separates the classifying front from the back, which
// handles one base per cycle in its run state. After the last character
// the back replays the stored first KMER_LEN-1 bases, one per cycle, then
// loads the result register once that register is free or being read.
// During that replay the queue fills and in_chan.ready drops.
// While out_chan stalls, the result waits in its register; the back keeps
// working on the next sequence until it has its own result ready.
// Reset (rst_n low, asynchronous) empties the queue, drops out_chan.valid
// and starts a fresh sequence.
module circular_canonical_min_kmer_hash (
    input  logic       clk,
    input  logic       rst_n,
    ccmk_in_if.sink    in_chan,
    ccmk_out_if.source out_chan
);

    logic            q_valid;
    logic            q_ready;
    ccmk_pkg::item_t q_item;

    ccmk_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_chan (in_chan),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    ccmk_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .out_chan (out_chan)
    );

endmodule
